@@ hw/rtl/wasp_pkg.sv @@
`default_nettype none

package wasp_pkg;

   // field widths
   localparam int OFFSET_BITS = 4;
   localparam int RANDOM_BITS = 8;
   localparam int NUM_PORTS   = 4;
   localparam int PORT_BITS   = 2;
   localparam int WEIGHT_BITS = 5;
   localparam int LOAD_BITS   = 7;
   localparam int SCORE_BITS  = 7;
   localparam int MASK_BITS   = 4;
   localparam int DIR_BITS    = 2;
   localparam int TIE_BITS    = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 7;

   // arrival directions
   localparam logic [DIR_BITS-1:0] DIR_FORWARD = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_BACK    = 2'd2;

   // output ports
   typedef enum logic [PORT_BITS-1:0] {
      PORT_EAST  = 2'd0,
      PORT_WEST  = 2'd1,
      PORT_NORTH = 2'd2,
      PORT_SOUTH = 2'd3
   } port_type;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PROGRESSIVE_WEIGHT = 2'd0,
      CSR_BUSY_WEIGHT        = 2'd1,
      CSR_LOAD_WEIGHT        = 2'd2,
      CSR_LOAD_THRESHOLD     = 2'd3
   } csr_index_type;

   // reset values of the weights and threshold
   localparam logic signed [WEIGHT_BITS-1:0] PROGRESSIVE_WEIGHT_RESET = 5'sd2;
   localparam logic signed [WEIGHT_BITS-1:0] BUSY_WEIGHT_RESET        = -5'sd1;
   localparam logic signed [WEIGHT_BITS-1:0] LOAD_WEIGHT_RESET        = -5'sd4;
   localparam logic [LOAD_BITS-1:0]          LOAD_THRESHOLD_RESET     = 7'd50;

   typedef struct packed {
      logic signed [WEIGHT_BITS-1:0] progressive_weight;
      logic signed [WEIGHT_BITS-1:0] busy_weight;
      logic signed [WEIGHT_BITS-1:0] load_weight;
      logic [LOAD_BITS-1:0]          load_threshold;
   } weights_type;

   // request beat, last member in the lowest bits
   typedef struct packed {
      logic [RANDOM_BITS-1:0] tie_random;
      logic [MASK_BITS-1:0]   busy_mask;
      logic [LOAD_BITS-1:0]   load_south;
      logic [LOAD_BITS-1:0]   load_north;
      logic [LOAD_BITS-1:0]   load_west;
      logic [LOAD_BITS-1:0]   load_east;
      logic                   y_south;
      logic [OFFSET_BITS-1:0] y_offset;
      logic                   x_east;
      logic [OFFSET_BITS-1:0] x_offset;
      logic [DIR_BITS-1:0]    arrival_direction;
      logic [MASK_BITS-1:0]   port_present;
   } req_item_type;

   // response beat, last member in the lowest bits
   typedef struct packed {
      logic [OFFSET_BITS-1:0]       new_y_offset;
      logic [OFFSET_BITS-1:0]       new_x_offset;
      logic signed [SCORE_BITS-1:0] best_score;
      logic [PORT_BITS-1:0]         selected_port;
   } rsp_item_type;

   typedef struct packed {
      logic         no_route;
      rsp_item_type data;
   } route_result_type;

   // one scored port
   typedef struct packed {
      logic                         cand;
      logic signed [SCORE_BITS-1:0] score;
   } port_eval_type;

   localparam int REQ_ITEM_BITS = $bits(req_item_type);
   localparam int REQ_DATA_BITS = ((REQ_ITEM_BITS + 7) / 8) * 8;
   localparam int RSP_ITEM_BITS = $bits(rsp_item_type);
   localparam int RSP_DATA_BITS = ((RSP_ITEM_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ hw/rtl/wasp_score.sv @@
`default_nettype none

module wasp_score (
   input  wire wasp_pkg::req_item_type  item,
   input  wire wasp_pkg::weights_type   weights,
   output wasp_pkg::port_eval_type      evals [wasp_pkg::NUM_PORTS]
);
   import wasp_pkg::*;

   logic [LOAD_BITS-1:0]         load [NUM_PORTS];
   logic [NUM_PORTS-1:0]         prog;
   logic signed [SCORE_BITS-1:0] prog_term;
   logic signed [SCORE_BITS-1:0] load_term;
   logic signed [SCORE_BITS-1:0] busy_term;

   assign load[PORT_EAST]  = item.load_east;
   assign load[PORT_WEST]  = item.load_west;
   assign load[PORT_NORTH] = item.load_north;
   assign load[PORT_SOUTH] = item.load_south;

   // ports that shorten a remaining offset
   assign prog[PORT_EAST]  = (item.x_offset != '0) &&  item.x_east;
   assign prog[PORT_WEST]  = (item.x_offset != '0) && !item.x_east;
   assign prog[PORT_NORTH] = (item.y_offset != '0) && !item.y_south;
   assign prog[PORT_SOUTH] = (item.y_offset != '0) &&  item.y_south;

   // weights widened once to score width
   assign prog_term = SCORE_BITS'(weights.progressive_weight);
   assign load_term = SCORE_BITS'(weights.load_weight);
   assign busy_term = SCORE_BITS'(weights.busy_weight);

   // candidate flag and score per port, even ports forward, odd ports back
   always_comb begin
      for (int p = 0; p < NUM_PORTS; p++) begin
         evals[p].cand  = item.port_present[p] &&
                          (((p % 2) == 0) ? (item.arrival_direction != DIR_FORWARD)
                                          : (item.arrival_direction != DIR_BACK));
         evals[p].score = (prog[p] ? prog_term : '0) +
                          ((load[p] > weights.load_threshold) ? load_term : '0) +
                          (item.busy_mask[p] ? busy_term : '0);
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/wasp_pick.sv @@
`default_nettype none

module wasp_pick (
   input  wire wasp_pkg::port_eval_type            evals [wasp_pkg::NUM_PORTS],
   input  wire [wasp_pkg::RANDOM_BITS-1:0]         tie_random,
   input  wire [wasp_pkg::OFFSET_BITS-1:0]         x_offset,
   input  wire [wasp_pkg::OFFSET_BITS-1:0]         y_offset,
   output wasp_pkg::route_result_type              result
);
   import wasp_pkg::*;

   localparam int PROD_BITS = RANDOM_BITS + TIE_BITS;

   logic                         have;
   logic signed [SCORE_BITS-1:0] best;
   logic [TIE_BITS-1:0]          ties;
   logic [PROD_BITS-1:0]         prod;
   logic [TIE_BITS-1:0]          pick;
   logic [TIE_BITS-1:0]          seen;
   logic                         found;
   logic [PORT_BITS-1:0]         chosen;

   // highest candidate score, first candidate seeds it
   always_comb begin
      have = 1'b0;
      best = '0;
      for (int p = 0; p < NUM_PORTS; p++) begin
         if (evals[p].cand && (!have || (evals[p].score > best))) begin
            best = evals[p].score;
         end
         have = have | evals[p].cand;
      end
   end

   // number of candidates sharing the best score
   always_comb begin
      ties = '0;
      for (int p = 0; p < NUM_PORTS; p++) begin
         ties = ties + TIE_BITS'(evals[p].cand && (evals[p].score == best));
      end
   end

   // tie index scaled from the random value
   assign prod = PROD_BITS'(tie_random) * PROD_BITS'(ties);
   assign pick = prod[RANDOM_BITS +: TIE_BITS];

   // walk the tied ports in ascending order
   always_comb begin
      seen   = '0;
      found  = 1'b0;
      chosen = PORT_EAST;
      for (int p = 0; p < NUM_PORTS; p++) begin
         if (!found && evals[p].cand && (evals[p].score == best)) begin
            if (seen == pick) begin
               chosen = PORT_BITS'(p);
               found  = 1'b1;
            end
            seen = seen + 1'b1;
         end
      end
   end

   // result with saturating offset update
   always_comb begin
      result = '0;
      if (!have) begin
         result.no_route = 1'b1;
      end else begin
         result.data.selected_port = chosen;
         result.data.best_score    = best;
         result.data.new_x_offset  = x_offset;
         result.data.new_y_offset  = y_offset;
         if ((chosen == PORT_EAST) || (chosen == PORT_WEST)) begin
            if (x_offset != '0) begin
               result.data.new_x_offset = x_offset - 1'b1;
            end
         end else begin
            if (y_offset != '0) begin
               result.data.new_y_offset = y_offset - 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/weighted_adaptive_port_select.sv @@
// the input and result registers form a two-entry pipeline from request to response
// throughput: one beat per cycle while rsp_tready is high; a request is taken while
//   a response waits if the input register is empty
// reset: synchronous active-high reset empties both registers and loads the weight
//   registers with 2, -1, -4 and threshold 50
`default_nettype none

module weighted_adaptive_port_select (
   input  wire                                 clock,
   input  wire                                 reset,
   // port_present, arrival_direction, x_offset, x_east, y_offset, y_south,
   // load_east, load_west, load_north, load_south, busy_mask, tie_random
   input  wire [wasp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // selected_port, best_score, new_x_offset, new_y_offset, zero fill
   output logic [wasp_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // no_route
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   input  wire                                 csr_we,
   input  wire [wasp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire [wasp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import wasp_pkg::*;

   weights_type      weights_ff, weights_in;
   logic             s1_valid_ff, s1_valid_in;
   req_item_type     s1_item_ff, s1_item_in;
   logic             out_valid_ff, out_valid_in;
   route_result_type out_result_ff, out_result_in;
   logic             s2_ready;
   port_eval_type    evals [NUM_PORTS];
   route_result_type result;

   // weight registers
   always_comb begin
      weights_in = weights_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PROGRESSIVE_WEIGHT: weights_in.progressive_weight = csr_wdata[WEIGHT_BITS-1:0];
            CSR_BUSY_WEIGHT:        weights_in.busy_weight        = csr_wdata[WEIGHT_BITS-1:0];
            CSR_LOAD_WEIGHT:        weights_in.load_weight        = csr_wdata[WEIGHT_BITS-1:0];
            CSR_LOAD_THRESHOLD:     weights_in.load_threshold     = csr_wdata[LOAD_BITS-1:0];
            default:                weights_in = weights_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff.progressive_weight <= PROGRESSIVE_WEIGHT_RESET;
         weights_ff.busy_weight        <= BUSY_WEIGHT_RESET;
         weights_ff.load_weight        <= LOAD_WEIGHT_RESET;
         weights_ff.load_threshold     <= LOAD_THRESHOLD_RESET;
      end else begin
         weights_ff <= weights_in;
      end
   end

   // pipeline handshake
   assign s2_ready   = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s2_ready;

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_item_in  = req_item_type'(req_tdata[REQ_ITEM_BITS-1:0]);
      end
   end

   // result register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      if (s2_ready) begin
         out_valid_in  = s1_valid_ff;
         out_result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff    <= s1_item_in;
      out_result_ff <= out_result_in;
   end

   // per-port scoring
   wasp_score u_score (
      .item    (s1_item_ff),
      .weights (weights_ff),
      .evals   (evals)
   );

   // best port and tie pick
   wasp_pick u_pick (
      .evals      (evals),
      .tie_random (s1_item_ff.tie_random),
      .x_offset   (s1_item_ff.x_offset),
      .y_offset   (s1_item_ff.y_offset),
      .result     (result)
   );

   // response beat
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.no_route;
   assign rsp_tdata  = RSP_DATA_BITS'(out_result_ff.data);

   // a response without a route carries all-zero data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("no_route response with nonzero data");

   // a filled input register reaches the result register when it is free
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_ready) |=> out_valid_ff)
      else $error("pipeline lost a beat between stages");

   // a stalled input register keeps its beat
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("input register changed while stalled");

   // an accepted request always lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted request beat dropped");

endmodule

`default_nettype wire
